// File: src/rtti_pkg.sv
// Shared types, codes and helper functions for the radix text-to-integer parser.
// Used by every module of the block; it depends on nothing else.
package rtti_pkg;

  // Field and port widths.
  localparam int ValW   = 64;
  localparam int StopW  = 16;
  localparam int CharW  = 8;
  localparam int RadixW = 6;
  localparam int RwW    = 7;
  localparam int IdxW   = 2;
  localparam int CfgW   = 7;

  // Register reset values.
  localparam logic [RadixW-1:0] RadixReset  = 6'd10;
  localparam logic              SignedReset = 1'b1;
  localparam logic [RwW-1:0]    WidthReset  = 7'd32;

  // Radix limits.
  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;

  // Characters of interest.
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowZ  = 8'h7a;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;
  localparam logic [CharW-1:0] LetterBias = 8'h57;   // 'a' - 10
  localparam logic [RadixW-1:0] NoDigit  = 6'd36;

  // Saturation point of the character counter.
  localparam logic [StopW-1:0] CountMax = {StopW{1'b1}};

  // Parse phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [IdxW-1:0] {
    REG_RADIX  = 2'd0,
    REG_SIGNED = 2'd1,
    REG_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  // Effective configuration handed to the parser.
  typedef struct packed {
    logic [RadixW-1:0] radix;
    logic              signed_mode;
    width_e            width;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic [ValW-1:0]  value;
    status_e          status;
    logic [StopW-1:0] stop;
  } result_t;

  // Digit value of a character, NoDigit when it is not in 0-9 or a-z.
  function automatic logic [RadixW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] off;
    if (c inside {[CharZero:CharNine]}) begin
      off = c - CharZero;
    end else if (c inside {[CharLowA:CharLowZ]}) begin
      off = c - LetterBias;
    end else begin
      off = {2'b00, NoDigit};
    end
    return off[RadixW-1:0];
  endfunction

  // Largest unsigned value of the destination width.
  function automatic logic [ValW-1:0] width_mask(input width_e w);
    logic [ValW-1:0] m;
    case (w)
      W8:      m = 64'h0000_0000_0000_00ff;
      W16:     m = 64'h0000_0000_0000_ffff;
      W32:     m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // Weight of the sign bit of the destination width.
  function automatic logic [ValW-1:0] sign_weight(input width_e w);
    logic [ValW-1:0] h;
    case (w)
      W8:      h = 64'h0000_0000_0000_0080;
      W16:     h = 64'h0000_0000_0000_8000;
      W32:     h = 64'h0000_0000_8000_0000;
      default: h = 64'h8000_0000_0000_0000;
    endcase
    return h;
  endfunction

endpackage

// File: src/rtti_cfg.sv
// Configuration registers of the parser and their decode to effective values.
// Depends on rtti_pkg.
module rtti_cfg import rtti_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output cfg_t            cfg_o
);

  logic [RadixW-1:0] radix_q, radix_d;
  logic              signed_q, signed_d;
  logic [RwW-1:0]    width_q, width_d;

  // Register write decode.
  always_comb begin
    radix_d  = radix_q;
    signed_d = signed_q;
    width_d  = width_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RADIX:  radix_d  = cfg_data_i[RadixW-1:0];
        REG_SIGNED: signed_d = cfg_data_i[0];
        REG_WIDTH:  width_d  = cfg_data_i[RwW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RadixReset;
      signed_q <= SignedReset;
      width_q  <= WidthReset;
    end else begin
      radix_q  <= radix_d;
      signed_q <= signed_d;
      width_q  <= width_d;
    end
  end

  // The radix saturates to its legal range; the width rounds up to a standard size.
  always_comb begin
    if (radix_q < RadixMin) begin
      cfg_o.radix = RadixMin;
    end else if (radix_q > RadixMax) begin
      cfg_o.radix = RadixMax;
    end else begin
      cfg_o.radix = radix_q;
    end
    cfg_o.signed_mode = signed_q;
    if (width_q <= 7'd8) begin
      cfg_o.width = W8;
    end else if (width_q <= 7'd16) begin
      cfg_o.width = W16;
    end else if (width_q <= 7'd32) begin
      cfg_o.width = W32;
    end else begin
      cfg_o.width = W64;
    end
  end

endmodule

// File: src/rtti_step.sv
// Input register and parse state: one character beat is folded into the accumulated
// magnitude per cycle unless the output register is held. Depends on rtti_pkg.
module rtti_step import rtti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             is_first_i,
  input  logic             is_last_i,
  input  cfg_t             cfg_i,
  input  logic             slot_free_i,
  output logic             load_o,
  output result_t          result_o
);

  // Input register.
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] char_q;
  logic             first_q;
  logic             last_q;

  // Parse state.
  logic [ValW-1:0]  mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [StopW-1:0] count_q, count_d;
  logic [1:0]       phase_q, phase_d;

  logic adv;

  // The held beat moves on when the output register can take a result.
  assign adv        = in_valid_q && slot_free_i;
  assign in_ready_o = !in_valid_q || adv;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q  <= char_code_i;
      first_q <= is_first_i;
      last_q  <= is_last_i;
    end
  end

  // Working view of the state: a first mark starts a fresh text.
  logic              active;
  logic [1:0]        cur_phase;
  logic [ValW-1:0]   cur_mag;
  logic              cur_neg;
  logic [StopW-1:0]  pos;
  logic [StopW-1:0]  count_n;
  logic [RadixW-1:0] dig;
  logic              is_digit;
  logic              is_minus;

  assign active    = first_q || (phase_q != PH_IDLE);
  assign cur_phase = first_q ? PH_START : phase_q;
  assign cur_mag   = first_q ? '0 : mag_q;
  assign cur_neg   = first_q ? 1'b0 : neg_q;
  assign pos       = first_q ? '0 : count_q;
  assign count_n   = (pos == CountMax) ? pos : pos + 16'd1;
  assign dig       = digit_of(char_q);
  assign is_digit  = dig < cfg_i.radix;
  assign is_minus  = (cur_phase == PH_START) && !cur_neg && cfg_i.signed_mode &&
                     (pos == '0) && (char_q == CharMinus);

  // Multiply-add with an exact overflow check against the destination width.
  logic [ValW+RadixW-1:0] prod;
  logic [ValW+RadixW:0]   acc;
  logic [ValW-1:0]        mask;
  logic                   ovf;

  assign mask = width_mask(cfg_i.width);
  assign prod = cur_mag * cfg_i.radix;
  assign acc  = {1'b0, prod} + {{(ValW+1){1'b0}}, dig};
  assign ovf  = acc > {{(RadixW+1){1'b0}}, mask};

  // Closing of a text: range check in signed mode and two's complement.
  logic [ValW-1:0] fin_mag;
  logic [ValW-1:0] half;
  status_e         fin_status;
  logic [ValW-1:0] fin_value;

  assign half = sign_weight(cfg_i.width);

  always_comb begin
    fin_status = ST_OK;
    // The width may have shrunk during the text, so an unsigned result is cut to it.
    fin_value  = fin_mag & mask;
    if (cfg_i.signed_mode) begin
      if (cur_neg) begin
        if (fin_mag > half) begin
          fin_status = ST_RANGE;
          fin_value  = '0;
        end else begin
          fin_value = '0 - fin_mag;
        end
      end else if (fin_mag >= half) begin
        fin_status = ST_RANGE;
        fin_value  = '0;
      end
    end
  end

  // Per-beat decision.
  always_comb begin
    mag_d           = mag_q;
    neg_d           = neg_q;
    count_d         = count_q;
    phase_d         = phase_q;
    fin_mag         = cur_mag;
    load_o          = 1'b0;
    result_o.value  = '0;
    result_o.status = ST_INVALID;
    result_o.stop   = pos;
    if (adv && active) begin
      mag_d   = cur_mag;
      neg_d   = cur_neg;
      count_d = count_n;
      if (cur_phase == PH_STOPPED) begin
        // Skipping the rest of a stopped text.
        phase_d = last_q ? PH_IDLE : PH_STOPPED;
      end else if (is_minus) begin
        // Leading minus sign.
        neg_d   = 1'b1;
        phase_d = last_q ? PH_IDLE : PH_START;
        if (last_q) begin
          load_o        = 1'b1;
          result_o.stop = count_n;
        end
      end else if (!is_digit) begin
        // Non-digit: close after digits, otherwise there is no number.
        load_o  = 1'b1;
        phase_d = last_q ? PH_IDLE : PH_STOPPED;
        if (cur_phase == PH_DIGITS) begin
          result_o.value  = fin_value;
          result_o.status = fin_status;
        end
      end else if (ovf) begin
        // The digit would exceed the destination width.
        load_o          = 1'b1;
        result_o.status = ST_RANGE;
        phase_d         = last_q ? PH_IDLE : PH_STOPPED;
      end else begin
        // Digit taken; the last one closes the text.
        mag_d   = acc[ValW-1:0];
        fin_mag = acc[ValW-1:0];
        phase_d = last_q ? PH_IDLE : PH_DIGITS;
        if (last_q) begin
          load_o          = 1'b1;
          result_o.value  = fin_value;
          result_o.status = fin_status;
          result_o.stop   = count_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      count_q <= '0;
      phase_q <= PH_IDLE;
    end else begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  // A first mark always restarts the count at one character.
  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && first_q |=> count_q == 16'd1)
    else $error("count not restarted by first mark");

  // Characters outside a text give no result.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !first_q && phase_q == PH_IDLE |-> !load_o)
    else $error("result from a character outside a text");

  // A result is only produced into a free output slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |-> slot_free_i && in_valid_q)
    else $error("result produced while output register is held");

endmodule

// File: src/rtti_out.sv
// Output register that holds one result beat until it is taken.
// Depends on rtti_pkg.
module rtti_out import rtti_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    slot_free_o,
  output result_t result_o
);

  logic    out_valid_q, out_valid_d;
  result_t result_q;

  // The slot is free when empty or being emptied in this cycle.
  assign slot_free_o = !out_valid_q || out_ready_i;
  assign out_valid_d = load_i || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // A failed parse carries a zero value.
  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.status != ST_OK |-> result_q.value == '0)
    else $error("nonzero value with error status");

  // No number found stops within the sign position.
  a_invalid_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.status == ST_INVALID |-> result_q.stop <= 16'd1)
    else $error("invalid status past the sign position");

endmodule

// File: src/radix_text_to_integer.sv
// Top level of the radix text-to-integer parser.
// Depends on rtti_pkg, rtti_cfg, rtti_step and rtti_out.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-----------------------------------------
//   cfg      | cfg_we_i                | cfg_index_i, cfg_data_i
//   in       | in_valid_i / in_ready_o | char_code_i, is_first_i, is_last_i
//   out      | out_valid_o/out_ready_i | parsed_value_o, status_o, stop_index_o
//
// One character beat is taken per cycle unless a held result stalls it. The
// multiply-add by the radix and the range checks work on the input register, so
// a result, if any, is written to the output register when the beat moves on.
// Reset clears the parse state to idle and restores the register defaults.
// A held result stalls the input register; a new beat is still taken in the
// cycle in which the held result is taken.
module radix_text_to_integer import rtti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             is_first_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  parsed_value_o,
  output logic [1:0]       status_o,
  output logic [StopW-1:0] stop_index_o
);

  cfg_t    cfg;
  logic    slot_free;
  logic    load;
  result_t step_res;
  result_t out_res;

  rtti_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rtti_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_first_i  (is_first_i),
    .is_last_i   (is_last_i),
    .cfg_i       (cfg),
    .slot_free_i (slot_free),
    .load_o      (load),
    .result_o    (step_res)
  );

  rtti_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .slot_free_o (slot_free),
    .result_o    (out_res)
  );

  // Result fields onto their ports.
  assign parsed_value_o = out_res.value;
  assign status_o       = out_res.status;
  assign stop_index_o   = out_res.stop;

endmodule
